// ===== rtl/tceq_pkg.sv =====
package tceq_pkg;

    localparam int POST_DEPTH   = 256;
    localparam int URGENT_DEPTH = 16;
    localparam int POST_AW      = $clog2(POST_DEPTH);

    localparam logic [2:0] OP_POST       = 3'd0;
    localparam logic [2:0] OP_URGENT     = 3'd1;
    localparam logic [2:0] OP_POP        = 3'd2;
    localparam logic [2:0] OP_CLEAR      = 3'd3;
    localparam logic [2:0] OP_REMOVE_ALL = 3'd4;

    typedef struct packed {
        logic [15:0] handler;
        logic [15:0] event_code;
        logic [31:0] word_param;
        logic [63:0] ptr_param;
    } t_event;

    localparam int EVW = $bits(t_event);

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] handler;
        logic [15:0] event_code;
        logic [31:0] word_param;
        logic [63:0] ptr_param;
    } t_in_beat;

    typedef struct packed {
        logic        accepted;
        logic        found;
        logic        from_urgent;
        logic [15:0] out_handler;
        logic [15:0] out_event_code;
        logic [31:0] out_word_param;
        logic [63:0] out_ptr_param;
        logic        is_empty;
    } t_out_beat;

    typedef struct packed {
        logic        push;
        logic        shift;
        logic        clear;
        logic        flush;
        logic [15:0] tag;
    } t_cell_ctrl;

    function automatic logic [POST_AW-1:0] post_next(input logic [POST_AW-1:0] idx);
        post_next = (idx == POST_AW'(POST_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

// ===== rtl/tceq_ram.sv =====
module tceq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tceq_cell.sv =====
module tceq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tceq_pkg::t_cell_ctrl i_ctrl,
    input  tceq_pkg::t_event    i_item,
    input  logic                i_prev_valid,
    input  logic                i_next_valid,
    input  tceq_pkg::t_event    i_next_entry,
    output logic                o_valid,
    output tceq_pkg::t_event    o_entry
);

    logic             r_valid;
    tceq_pkg::t_event r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.flush) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_next_valid;
            r_entry <= i_next_entry;
        end else if (i_ctrl.push && !r_valid && i_prev_valid) begin
            r_valid <= 1'b1;
            r_entry <= i_item;
        end else if (i_ctrl.clear && r_valid && r_entry.handler == i_ctrl.tag) begin
            r_entry.handler <= '0;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

// ===== rtl/two_class_event_queue.sv =====
// Channel  Valid        Ready        Data         Beat
// in       i_in_valid   o_in_ready   i_in_data    one operation (t_in_beat)
// out      o_out_valid  i_out_ready  o_out_data   one result (t_out_beat)
//
// Adds, remove-all, urgent pops and empty pops are answered directly from the idle state.
// A posted pop goes through S_POP for one registered read of the post RAM.
// A clear with posted events queued walks the post RAM in S_CLEAR; with none it answers from idle.
// Synchronous active-low reset empties both classes; no clearing pass.
// A two-entry output stage takes one beat while a result waits; a full stage stalls input.
module two_class_event_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tceq_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tceq_pkg::t_out_beat o_out_data
);

    localparam int UD = tceq_pkg::URGENT_DEPTH;
    localparam int AW = tceq_pkg::POST_AW;

    typedef enum logic [1:0] {S_IDLE, S_POP, S_CLEAR} t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_rd, n_rd;
    logic [AW-1:0]        r_wr, n_wr;
    logic [AW-1:0]        r_walk, n_walk;
    logic                 r_chk_valid, n_chk_valid;
    logic [AW-1:0]        r_chk_addr, n_chk_addr;
    logic [15:0]          r_tag, n_tag;
    logic                 r_out_valid, n_out_valid;
    tceq_pkg::t_out_beat  r_out, n_out;
    logic                 r_skid_valid, n_skid_valid;
    tceq_pkg::t_out_beat  r_skid, n_skid;

    tceq_pkg::t_cell_ctrl ctrl;
    tceq_pkg::t_event     item;
    tceq_pkg::t_event     u_ent [UD+1];
    logic [UD-1:0]        u_valid;
    logic [UD-1:0]        u_next;
    logic [UD-1:0]        u_prev;

    logic                 we;
    logic [AW-1:0]        waddr;
    tceq_pkg::t_event     wdata;
    logic [AW-1:0]        raddr;
    tceq_pkg::t_event     rdata;

    logic                 in_acc;
    logic                 take;
    logic                 post_empty;
    logic                 post_full;
    logic                 u_empty;
    logic                 u_full;
    logic                 res_valid;
    tceq_pkg::t_out_beat  res;

    assign item = '{handler:    i_in_data.handler,
                    event_code: i_in_data.event_code,
                    word_param: i_in_data.word_param,
                    ptr_param:  i_in_data.ptr_param};

    assign u_next    = {1'b0, u_valid[UD-1:1]};
    assign u_prev    = {u_valid[UD-2:0], 1'b1};
    assign u_ent[UD] = '0;

    for (genvar g = 0; g < UD; g++) begin : g_cell
        tceq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_item       (item),
            .i_prev_valid (u_prev[g]),
            .i_next_valid (u_next[g]),
            .i_next_entry (u_ent[g+1]),
            .o_valid      (u_valid[g]),
            .o_entry      (u_ent[g])
        );
    end

    tceq_ram #(
        .WIDTH (tceq_pkg::EVW),
        .DEPTH (tceq_pkg::POST_DEPTH)
    ) u_post_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !r_skid_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign take        = r_out_valid && i_out_ready;
    assign post_empty  = (r_rd == r_wr);
    assign post_full   = (tceq_pkg::post_next(r_wr) == r_rd);
    assign u_empty     = !u_valid[0];
    assign u_full      = u_valid[UD-1];

    always_comb begin
        n_state     = r_state;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_walk      = r_walk;
        n_chk_valid = r_chk_valid;
        n_chk_addr  = r_chk_addr;
        n_tag       = r_tag;
        ctrl        = '0;
        ctrl.tag    = i_in_data.handler;
        we          = 1'b0;
        waddr       = r_wr;
        wdata       = item;
        raddr       = r_rd;
        res_valid   = 1'b0;
        res         = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    res_valid    = 1'b1;
                    res.is_empty = u_empty && post_empty;
                    case (i_in_data.op)
                        tceq_pkg::OP_POST: begin
                            if (!post_full) begin
                                we           = 1'b1;
                                n_wr         = tceq_pkg::post_next(r_wr);
                                res.accepted = 1'b1;
                                res.is_empty = 1'b0;
                            end
                        end
                        tceq_pkg::OP_URGENT: begin
                            if (!u_full) begin
                                ctrl.push    = 1'b1;
                                res.accepted = 1'b1;
                                res.is_empty = 1'b0;
                            end
                        end
                        tceq_pkg::OP_POP: begin
                            if (!u_empty) begin
                                ctrl.shift         = 1'b1;
                                res.found          = 1'b1;
                                res.from_urgent    = 1'b1;
                                res.out_handler    = u_ent[0].handler;
                                res.out_event_code = u_ent[0].event_code;
                                res.out_word_param = u_ent[0].word_param;
                                res.out_ptr_param  = u_ent[0].ptr_param;
                                res.is_empty       = !u_next[0] && post_empty;
                            end else if (!post_empty) begin
                                n_rd      = tceq_pkg::post_next(r_rd);
                                n_state   = S_POP;
                                res_valid = 1'b0;
                            end
                        end
                        tceq_pkg::OP_CLEAR: begin
                            ctrl.clear = 1'b1;
                            n_tag      = i_in_data.handler;
                            if (!post_empty) begin
                                n_walk      = r_rd;
                                n_chk_valid = 1'b0;
                                n_state     = S_CLEAR;
                                res_valid   = 1'b0;
                            end
                        end
                        tceq_pkg::OP_REMOVE_ALL: begin
                            ctrl.flush   = 1'b1;
                            n_rd         = '0;
                            n_wr         = '0;
                            res.is_empty = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                res_valid          = 1'b1;
                res.found          = 1'b1;
                res.out_handler    = rdata.handler;
                res.out_event_code = rdata.event_code;
                res.out_word_param = rdata.word_param;
                res.out_ptr_param  = rdata.ptr_param;
                res.is_empty       = u_empty && post_empty;
                n_state            = S_IDLE;
            end
            S_CLEAR: begin
                raddr = r_walk;
                if (r_walk != r_wr) begin
                    n_chk_valid = 1'b1;
                    n_chk_addr  = r_walk;
                    n_walk      = tceq_pkg::post_next(r_walk);
                end else begin
                    n_chk_valid = 1'b0;
                end
                if (r_chk_valid && rdata.handler == r_tag) begin
                    we            = 1'b1;
                    waddr         = r_chk_addr;
                    wdata         = rdata;
                    wdata.handler = '0;
                end
                if (r_walk == r_wr && !r_chk_valid) begin
                    res_valid    = 1'b1;
                    res.is_empty = u_empty && post_empty;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (res_valid) begin
            if (!r_out_valid || take) begin
                n_out_valid = 1'b1;
                n_out       = res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = res;
            end
        end else if (take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd         <= '0;
            r_wr         <= '0;
            r_chk_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd         <= n_rd;
            r_wr         <= n_wr;
            r_walk       <= n_walk;
            r_chk_valid  <= n_chk_valid;
            r_chk_addr   <= n_chk_addr;
            r_tag        <= n_tag;
            r_out_valid  <= n_out_valid;
            r_out        <= n_out;
            r_skid_valid <= n_skid_valid;
            r_skid       <= n_skid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output beat");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((u_valid + UD'(1)) & u_valid) == '0)
        else $error("urgent cells not packed toward the head");

    a_remove_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.op == tceq_pkg::OP_REMOVE_ALL) |=> (r_rd == r_wr && !u_valid[0]))
        else $error("queue not empty after remove-all");

    a_chk_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> r_state == S_CLEAR)
        else $error("clear check pending outside the walk");

    a_post_pop_no_urgent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> u_empty)
        else $error("posted pop while urgent events queued");

endmodule
